>>> rtl/dcq_pkg.sv
package dcq_pkg;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_CANCEL   = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_PROCESS  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_ASYNC   = 2'd1,
    KIND_BARRIER = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    RESP_ADD      = 2'd0,
    RESP_COMPLETE = 2'd1,
    RESP_DISPATCH = 2'd2
  } resp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        obj_tag;
    logic               any_object;
    logic signed [31:0] result_code;
    logic [1:0]         res_kind;
    logic [15:0]        seq_number;
    logic [31:0]        cancel_id;
    logic               any_id;
    logic               callback_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         resp_kind;
    logic [31:0]        item_id;
    logic               accepted;
    logic [15:0]        obj_tag_out;
    logic signed [31:0] result_out;
    logic [4:0]         queued_count;
    logic               last;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] obj;
    logic        pending;
    logic [15:0] seq;
    logic [31:0] result;
    logic        barrier;
    logic        live;
  } entry_t;

endpackage

>>> rtl/deferred_completion_queue_unit.sv
// Deferred completion queue: an ordered table of up to QUEUE_DEPTH entries held
// in a register array and swept by one entry-compare unit, one slot per cycle
// unless a dispatch waits on the output port. An add answer is valid the cycle
// after the request beat, and the next request is taken once that answer has
// been taken. Cancel sweeps every queued entry and gives no answer; in_ready
// returns when the sweep ends. Complete sweeps the same way and then loads its
// answer from the emit state. Process sweeps the same way, stalling on each
// dispatch that finds the previous beat still not taken, and then sends the
// final beat from the emit state when anything was dispatched.
// A dispatch beat is held until the next one so that last can be set on the final one.
// in_ready is low during a sweep and while an answer beat is waiting.
// Entry payload fields have no reset.
module deferred_completion_queue_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dcq_pkg::out_item_t  out_data
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dcq_pkg::entry_t          tab [QUEUE_DEPTH];
  logic [31:0]              id_counter;
  logic [CW-1:0]            queued;
  dcq_pkg::state_t          state, state_next;
  dcq_pkg::in_item_t        req;
  logic [CW-1:0]            rd, wr, total;
  logic                     hit;
  dcq_pkg::entry_t          cur;
  logic                     take, match_c, match_p;
  logic                     in_fire, full, is_proc, dispatch, port_free;
  logic                     step, out_load;
  dcq_pkg::out_item_t       obuf, out_next, hold;
  logic                     ovalid, hold_valid;

  assign in_ready  = (state == dcq_pkg::ST_IDLE) && !ovalid;
  assign out_valid = ovalid;
  assign out_data  = obuf;
  assign in_fire   = in_valid && in_ready;
  assign full      = (queued >= CW'(QUEUE_DEPTH));
  assign port_free = !ovalid || out_ready;

  // shared compare unit on the slot under the read pointer
  always_comb begin
    cur     = tab[rd[IW-1:0]];
    match_c = (req.any_id || cur.id == req.cancel_id) &&
              (req.any_object || cur.obj == req.obj_tag);
    match_p = cur.pending && cur.obj == req.obj_tag && cur.seq == req.seq_number;
    if (cur.pending) take = 1'b0;
    else if (cur.barrier) take = (wr == '0);
    else take = 1'b1;
  end

  assign is_proc  = (req.req_type == dcq_pkg::REQ_PROCESS);
  assign dispatch = is_proc && take && cur.live;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, sweep step and output beat
  always_comb begin
    state_next = state;
    step       = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    case (state)
      dcq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.req_type == dcq_pkg::REQ_ADD) begin
            out_load           = 1'b1;
            out_next.resp_kind = dcq_pkg::RESP_ADD;
            out_next.last      = 1'b1;
            if (full) begin
              out_next.queued_count = 5'(queued);
            end else begin
              out_next.item_id      = id_counter + 32'd1;
              out_next.accepted     = 1'b1;
              out_next.queued_count = 5'(queued + CW'(1));
            end
          end else begin
            state_next = dcq_pkg::ST_SCAN;
          end
        end
      end
      dcq_pkg::ST_SCAN: begin
        if (rd == total) begin
          if (req.req_type == dcq_pkg::REQ_COMPLETE || (is_proc && hold_valid)) begin
            state_next = dcq_pkg::ST_EMIT;
          end else begin
            state_next = dcq_pkg::ST_IDLE;
          end
        end else if (!(dispatch && hold_valid && !port_free)) begin
          // a new dispatch releases the held beat to the port
          step = 1'b1;
          if (dispatch && hold_valid) begin
            out_load = 1'b1;
            out_next = hold;
          end
        end
      end
      dcq_pkg::ST_EMIT: begin
        if (port_free) begin
          out_load   = 1'b1;
          state_next = dcq_pkg::ST_IDLE;
          if (req.req_type == dcq_pkg::REQ_COMPLETE) begin
            out_next.resp_kind    = dcq_pkg::RESP_COMPLETE;
            out_next.accepted     = hit;
            out_next.queued_count = 5'(queued);
            out_next.last         = 1'b1;
          end else begin
            out_next      = hold;
            out_next.last = 1'b1;
          end
        end
      end
      default: state_next = dcq_pkg::ST_IDLE;
    endcase
  end

  // table, counters and beat registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= '0;
      queued     <= '0;
      ovalid     <= 1'b0;
      rd         <= '0;
      wr         <= '0;
      total      <= '0;
      hit        <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      ovalid <= out_load || (ovalid && !out_ready);
      if (out_load) obuf <= out_next;

      // request beat: start a sweep or append an entry
      if (in_fire) begin
        req        <= in_data;
        rd         <= '0;
        wr         <= '0;
        total      <= queued;
        hit        <= 1'b0;
        hold_valid <= 1'b0;
        if (in_data.req_type == dcq_pkg::REQ_ADD && !full) begin
          tab[queued[IW-1:0]].id      <= id_counter + 32'd1;
          tab[queued[IW-1:0]].obj     <= in_data.obj_tag;
          tab[queued[IW-1:0]].pending <= (in_data.res_kind == dcq_pkg::KIND_ASYNC);
          tab[queued[IW-1:0]].seq     <= (in_data.res_kind == dcq_pkg::KIND_ASYNC) ?
                                          in_data.seq_number : 16'd0;
          tab[queued[IW-1:0]].result  <= in_data.result_code;
          tab[queued[IW-1:0]].barrier <= (in_data.res_kind == dcq_pkg::KIND_BARRIER);
          tab[queued[IW-1:0]].live    <= in_data.callback_present;
          id_counter                  <= id_counter + 32'd1;
          queued                      <= queued + CW'(1);
        end
      end

      // one slot of the sweep
      if (step) begin
        rd <= rd + CW'(1);
        case (req.req_type)
          dcq_pkg::REQ_CANCEL: begin
            if (match_c) begin
              tab[rd[IW-1:0]].pending <= 1'b0;
              tab[rd[IW-1:0]].live    <= 1'b0;
            end
          end
          dcq_pkg::REQ_COMPLETE: begin
            if (match_p) begin
              tab[rd[IW-1:0]].pending <= 1'b0;
              tab[rd[IW-1:0]].result  <= req.result_code;
              hit <= 1'b1;
            end
          end
          dcq_pkg::REQ_PROCESS: begin
            if (!take) begin
              tab[wr[IW-1:0]] <= cur;
              wr <= wr + CW'(1);
            end else begin
              queued <= queued - CW'(1);
              if (cur.live) begin
                hold.resp_kind    <= dcq_pkg::RESP_DISPATCH;
                hold.item_id      <= cur.id;
                hold.accepted     <= 1'b0;
                hold.obj_tag_out  <= cur.obj;
                hold.result_out   <= cur.result;
                hold.queued_count <= 5'(queued - CW'(1));
                hold.last         <= 1'b0;
                hold_valid        <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      // final dispatch beat leaves the hold register
      if (state == dcq_pkg::ST_EMIT && port_free) hold_valid <= 1'b0;
    end
  end

endmodule

>>> bench/deferred_completion_queue_unit_tb.sv
module deferred_completion_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 4000;

  // shadow table, oldest entry first
  typedef struct {
    logic [31:0] id;
    logic [15:0] obj;
    bit          pending;
    logic [15:0] seq;
    logic [31:0] result;
    bit          barrier;
    bit          live;
  } slot_t;

  class dcq_scoreboard;
    slot_t                table_q[$];
    logic [31:0]          next_id;
    dcq_pkg::out_item_t   pending_beats[$];
    int                   errors;
    int                   reported;

    function void clear();
      table_q.delete();
      next_id = '0;
      pending_beats.delete();
      errors = 0;
      reported = 0;
    endfunction

    // model one accepted request and queue the beats it should produce
    function void note_request(dcq_pkg::in_item_t req);
      dcq_pkg::out_item_t b;
      slot_t       s;
      slot_t       kept[$];
      bit          hit;
      int          first_beat;
      first_beat = pending_beats.size();
      b = '0;
      case (dcq_pkg::req_t'(req.req_type))
        dcq_pkg::REQ_ADD: begin
          b.resp_kind = dcq_pkg::RESP_ADD;
          b.last = 1'b1;
          if (table_q.size() < DEPTH) begin
            next_id = next_id + 32'd1;
            s.id = next_id;
            s.obj = req.obj_tag;
            s.pending = (req.res_kind == dcq_pkg::KIND_ASYNC);
            s.seq = s.pending ? req.seq_number : '0;
            s.result = req.result_code;
            s.barrier = (req.res_kind == dcq_pkg::KIND_BARRIER);
            s.live = req.callback_present;
            table_q.push_back(s);
            b.item_id = next_id;
            b.accepted = 1'b1;
          end
          b.queued_count = 5'(table_q.size());
          pending_beats.push_back(b);
        end
        dcq_pkg::REQ_CANCEL: begin
          foreach (table_q[i])
            if ((req.any_id || table_q[i].id == req.cancel_id) &&
                (req.any_object || table_q[i].obj == req.obj_tag)) begin
              table_q[i].pending = 0;
              table_q[i].live = 0;
            end
        end
        dcq_pkg::REQ_COMPLETE: begin
          hit = 0;
          foreach (table_q[i])
            if (table_q[i].pending && table_q[i].obj == req.obj_tag &&
                table_q[i].seq == req.seq_number) begin
              table_q[i].pending = 0;
              table_q[i].result = req.result_code;
              hit = 1;
            end
          b.resp_kind = dcq_pkg::RESP_COMPLETE;
          b.accepted = hit;
          b.queued_count = 5'(table_q.size());
          b.last = 1'b1;
          pending_beats.push_back(b);
        end
        default: begin
          // count drops as each entry is taken, so track it along the scan
          int remaining;
          remaining = table_q.size();
          foreach (table_q[i]) begin
            bit take;
            if (table_q[i].pending) take = 0;
            else if (table_q[i].barrier) take = (kept.size() == 0);
            else take = 1;
            if (!take) begin
              kept.push_back(table_q[i]);
            end else begin
              remaining--;
              if (table_q[i].live) begin
                b = '0;
                b.resp_kind = dcq_pkg::RESP_DISPATCH;
                b.item_id = table_q[i].id;
                b.obj_tag_out = table_q[i].obj;
                b.result_out = table_q[i].result;
                b.queued_count = 5'(remaining);
                pending_beats.push_back(b);
              end
            end
          end
          table_q = kept;
          if (pending_beats.size() > first_beat)
            pending_beats[pending_beats.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    function void check_beat(dcq_pkg::out_item_t got);
      dcq_pkg::out_item_t exp_b;
      if (pending_beats.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected beat %p", got);
        end
        return;
      end
      exp_b = pending_beats.pop_front();
      if (got !== exp_b) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("beat mismatch: expected %p actual %p", exp_b, got);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  dcq_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  dcq_pkg::out_item_t out_data;

  dcq_scoreboard sb;
  int          idle_cycles;
  logic [15:0] seen_objs[$];
  logic [15:0] seen_seqs[$];

  deferred_completion_queue_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL deferred_completion_queue_unit");
        $finish;
      end
    end
  end

  // note accepted requests and check results at the edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(in_data);
    if (!rst && out_valid && out_ready) sb.check_beat(out_data);
  end

  // receiver with random stalls, occasionally none for a stretch
  initial begin
    int wait_n;
    out_ready = 0;
    @(negedge rst);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (wait_n > 0) begin
        out_ready <= 0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(dcq_pkg::in_item_t item, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic dcq_pkg::in_item_t blank_item(dcq_pkg::req_t op);
    dcq_pkg::in_item_t it;
    it = '0;
    it.req_type = op;
    return it;
  endfunction

  function automatic dcq_pkg::in_item_t rand_item();
    dcq_pkg::in_item_t it;
    int pick;
    it.req_type = 2'($urandom_range(0, 3));
    it.obj_tag = (seen_objs.size() > 0 && $urandom_range(0, 3) != 0) ?
                 seen_objs[$urandom_range(0, seen_objs.size()-1)] : 16'($urandom());
    it.any_object = ($urandom_range(0, 3) == 0);
    it.result_code = $urandom();
    it.res_kind = 2'($urandom_range(0, 3));
    it.seq_number = (seen_seqs.size() > 0 && $urandom_range(0, 3) != 0) ?
                    seen_seqs[$urandom_range(0, seen_seqs.size()-1)] : 16'($urandom());
    pick = $urandom_range(0, 3);
    it.cancel_id = (pick != 0) ? sb.next_id - 32'($urandom_range(0, 20)) : $urandom();
    it.any_id = ($urandom_range(0, 4) == 0);
    it.callback_present = ($urandom_range(0, 4) != 0);
    // weight toward adds so the table fills
    if ($urandom_range(0, 9) < 3) it.req_type = dcq_pkg::REQ_ADD;
    if (it.req_type == dcq_pkg::REQ_ADD) begin
      if (seen_objs.size() < 8) seen_objs.push_back(it.obj_tag);
      if (seen_seqs.size() < 8) seen_seqs.push_back(it.seq_number);
    end
    return it;
  endfunction

  task automatic drain_wait();
    in_valid <= 0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    dcq_pkg::in_item_t it;
    int gap;
    sb = new();
    sb.clear();
    in_valid = 0;
    in_data = '0;
    rst = 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty process, complete miss, extremes, barrier, cancel wildcards
    send_beat(blank_item(dcq_pkg::REQ_PROCESS), 0);
    it = blank_item(dcq_pkg::REQ_COMPLETE); it.obj_tag = 16'hFFFF;
    it.seq_number = 16'hFFFF;
    send_beat(it, 0);
    it = blank_item(dcq_pkg::REQ_ADD); it.obj_tag = 16'hFFFF;
    it.result_code = 32'h7FFFFFFF;
    it.res_kind = dcq_pkg::KIND_ASYNC; it.seq_number = 16'hFFFF; it.callback_present = 1;
    send_beat(it, 1);
    it = blank_item(dcq_pkg::REQ_ADD); it.result_code = 32'h80000000;
    it.res_kind = dcq_pkg::KIND_BARRIER;
    it.callback_present = 1;
    send_beat(it, 0);
    it = blank_item(dcq_pkg::REQ_ADD); it.obj_tag = 16'h0001; it.res_kind = 2'd3;
    it.result_code = -1; it.callback_present = 1;
    send_beat(it, 0);
    it = blank_item(dcq_pkg::REQ_ADD); it.obj_tag = 16'h0001;
    it.res_kind = dcq_pkg::KIND_PLAIN;
    send_beat(it, 2);
    send_beat(blank_item(dcq_pkg::REQ_PROCESS), 0);
    it = blank_item(dcq_pkg::REQ_COMPLETE); it.obj_tag = 16'hFFFF;
    it.seq_number = 16'hFFFF;
    it.result_code = 32'h12345678;
    send_beat(it, 0);
    send_beat(blank_item(dcq_pkg::REQ_PROCESS), 0);
    send_beat(blank_item(dcq_pkg::REQ_PROCESS), 0);
    // fill past capacity, then add when full
    for (int k = 0; k < DEPTH + 1; k++) begin
      it = blank_item(dcq_pkg::REQ_ADD); it.obj_tag = k[15:0];
      it.res_kind = dcq_pkg::KIND_ASYNC;
      it.seq_number = k[15:0]; it.callback_present = 1;
      send_beat(it, 0);
    end
    it = blank_item(dcq_pkg::REQ_CANCEL); it.cancel_id = 32'hFFFFFFFF; it.any_object = 1;
    send_beat(it, 0);
    it = blank_item(dcq_pkg::REQ_CANCEL); it.obj_tag = 16'd3; it.any_id = 1;
    send_beat(it, 0);
    it = blank_item(dcq_pkg::REQ_CANCEL); it.any_id = 1; it.any_object = 1;
    send_beat(it, 0);
    send_beat(blank_item(dcq_pkg::REQ_PROCESS), 0);

    // hold off until the block has answered everything
    drain_wait();

    // random traffic
    for (int k = 0; k < 260; k++) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
      if (k == 130) drain_wait();
      send_beat(rand_item(), gap);
    end

    drain_wait();
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("PASS deferred_completion_queue_unit");
    end else begin
      $display("FAIL deferred_completion_queue_unit");
    end
    $finish;
  end
endmodule
